// ===== rtl/core/tcgr_pkg.sv =====
package tcgr_pkg;

  localparam int unsigned GlyphLines = 16;
  localparam int unsigned LineW      = 4;
  localparam int unsigned CodeW      = 8;
  localparam int unsigned AddrW      = CodeW + LineW;
  localparam int unsigned PixW       = 16;
  localparam int unsigned CellW      = 6;

  localparam logic [CodeW-1:0] CHR_NUL   = 8'h00;
  localparam logic [CodeW-1:0] CHR_BS    = 8'h08;
  localparam logic [CodeW-1:0] CHR_NL    = 8'h0A;
  localparam logic [CodeW-1:0] CHR_CR    = 8'h0D;
  localparam logic [CodeW-1:0] CHR_SPACE = 8'h20;

  localparam logic REQ_PRINT = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  localparam logic KIND_GLYPH  = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  localparam logic [LineW-1:0] LINE_LAST = 4'hF;

  // glyph store access from the sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [PixW-1:0]  wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // result fields, known in the cycle before the glyph read data
  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [CellW-1:0] column;
    logic [CellW-1:0] text_row;
    logic [LineW-1:0] pixel_line;
    logic             last;
  } res_t;

endpackage

// ===== rtl/core/tcgr_glyph_mem.sv =====
module tcgr_glyph_mem
  import tcgr_pkg::*;
(
  input  logic            clk_i,
  input  mem_req_t        req_i,
  output logic [PixW-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << AddrW;

  logic [PixW-1:0] mem [Depth];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tcgr_seq.sv =====
module tcgr_seq
  import tcgr_pkg::*;
#(
  parameter int unsigned COLUMNS = 64,
  parameter int unsigned ROWS    = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             req_type_i,
  input  logic [CodeW-1:0] char_code_i,
  input  logic [LineW-1:0] glyph_line_i,
  input  logic [PixW-1:0]  row_bits_i,
  output logic             busy_o,
  output mem_req_t         mem_req_o,
  output res_t             res_o
);

  localparam logic [CellW-1:0] ColLast = CellW'(COLUMNS - 1);
  localparam logic [CellW-1:0] RowLast = CellW'(ROWS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_SCROLL
  } state_e;

  state_e           state_q, state_d;
  logic [CellW-1:0] col_q, col_d;
  logic [CellW-1:0] row_q, row_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [LineW-1:0] line_q, line_d;
  logic             bs_q, bs_d;
  logic [AddrW-1:0] clr_q, clr_d;

  logic             wrap;
  logic             scr;
  logic [CellW-1:0] col_n;

  assign wrap = (col_q == ColLast);
  assign scr  = wrap && (row_q == RowLast);

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    code_d    = code_q;
    line_d    = line_q;
    bs_d      = bs_q;
    clr_d     = clr_q;
    mem_req_o = '0;
    res_o     = '0;
    col_n     = wrap ? '0 : col_q + CellW'(1);

    case (state_q)
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        clr_d           = clr_q + AddrW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept_i) begin
          if (req_type_i == REQ_LOAD) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = {char_code_i, glyph_line_i};
            mem_req_o.wdata = row_bits_i;
          end else begin
            case (char_code_i)
              CHR_NL: begin
                col_d = '0;
                if (row_q == RowLast) begin
                  state_d = ST_SCROLL;
                end else begin
                  row_d = row_q + CellW'(1);
                end
              end
              CHR_CR: begin
                col_d = '0;
              end
              CHR_BS: begin
                col_d   = (col_q != '0) ? col_q - CellW'(1) : '0;
                code_d  = CHR_SPACE;
                bs_d    = 1'b1;
                line_d  = '0;
                state_d = ST_DRAW;
              end
              CHR_NUL: begin
              end
              default: begin
                code_d  = char_code_i;
                bs_d    = 1'b0;
                line_d  = '0;
                state_d = ST_DRAW;
              end
            endcase
          end
        end
      end
      ST_DRAW: begin
        mem_req_o.raddr  = {code_q, line_q};
        res_o.valid      = 1'b1;
        res_o.kind       = KIND_GLYPH;
        res_o.column     = col_q;
        res_o.text_row   = row_q;
        res_o.pixel_line = line_q;
        res_o.last       = (line_q == LINE_LAST) && !scr;
        line_d           = line_q + LineW'(1);
        if (line_q == LINE_LAST) begin
          // advance, wrap; backspace steps back again after the blank
          if (wrap && !scr) begin
            row_d = row_q + CellW'(1);
          end
          col_d   = bs_q ? ((col_n != '0) ? col_n - CellW'(1) : '0) : col_n;
          state_d = scr ? ST_SCROLL : ST_IDLE;
        end
      end
      ST_SCROLL: begin
        res_o.valid = 1'b1;
        res_o.kind  = KIND_SCROLL;
        res_o.last  = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      col_q   <= '0;
      row_q   <= '0;
      code_q  <= '0;
      line_q  <= '0;
      bs_q    <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      code_q  <= code_d;
      line_q  <= line_d;
      bs_q    <= bs_d;
      clr_q   <= clr_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/text_console_glyph_renderer.sv =====
// Text console renderer: character bytes in, 16x16 glyph row writes out.
// Request: start with req_type_i/char_code_i/glyph_line_i/row_bits_i, taken
//   on a rising edge with start high and busy low.
// Font load (req_type_i = 1) writes one glyph row and gives no result.
// Printable byte: 16 glyph row results back to back, plus one
//   scroll result when the cursor runs past the last row; busy while the
//   sequencer issues them. The glyph store, with separate read and write ports, reads one row per cycle.
// Newline gives at most one scroll result; CR and NUL give none. Backspace
//   draws a blank like a printable byte.
// Results appear in the cycle after the row is addressed in the sequencer:
//   the first row is on the ports from the edge after acceptance, with
//   result_valid_o high for exactly one cycle each; last_o marks the final
//   result of a request.
// The receiver cannot stall: results must be taken as they come.
// Reset clears the cursor, then sweeps zeros through the 4096-row glyph
//   store, one row a cycle; busy stays high until the sweep is done.
module text_console_glyph_renderer
  import tcgr_pkg::*;
#(
  parameter int unsigned COLUMNS = 64,
  parameter int unsigned ROWS    = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             req_type_i,
  input  logic [CodeW-1:0] char_code_i,
  input  logic [LineW-1:0] glyph_line_i,
  input  logic [PixW-1:0]  row_bits_i,
  output logic             result_valid_o,
  output logic             kind_o,
  output logic [CellW-1:0] column_o,
  output logic [CellW-1:0] text_row_o,
  output logic [LineW-1:0] pixel_line_o,
  output logic [PixW-1:0]  pixels_o,
  output logic             last_o
);

  mem_req_t        mem_req;
  res_t            res;
  res_t            res_q;
  logic [PixW-1:0] rdata;

  tcgr_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (start && !busy),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .glyph_line_i (glyph_line_i),
    .row_bits_i   (row_bits_i),
    .busy_o       (busy),
    .mem_req_o    (mem_req),
    .res_o        (res)
  );

  tcgr_glyph_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // align result fields with the registered store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res;
    end
  end

  assign result_valid_o = res_q.valid;
  assign kind_o         = res_q.kind;
  assign column_o       = res_q.column;
  assign text_row_o     = res_q.text_row;
  assign pixel_line_o   = res_q.pixel_line;
  assign pixels_o       = (res_q.kind == KIND_GLYPH) ? rdata : '0;
  assign last_o         = res_q.last;

`ifndef SYNTHESIS
  a_scroll_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KIND_SCROLL) |-> last_o)
    else $error("scroll result not marked last");

  a_rows_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KIND_GLYPH) && (pixel_line_o != LINE_LAST)
    |=> result_valid_o && (kind_o == KIND_GLYPH) &&
        (pixel_line_o == $past(pixel_line_o) + LineW'(1)))
    else $error("glyph rows not consecutive");

  a_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KIND_GLYPH)
    |-> (int'(column_o) < COLUMNS) && (int'(text_row_o) < ROWS))
    else $error("cell outside console");

  a_busy_while_drawing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("request taken while results pending");
`endif

endmodule

// ===== tb/sv/text_console_glyph_renderer_test.sv =====
`timescale 1ns / 100ps

module text_console_glyph_renderer_test;
  import tcgr_pkg::*;

  localparam int unsigned Columns       = 64;
  localparam int unsigned Rows          = 48;
  localparam int unsigned NumItems      = 420;
  // the limit outlasts the reset sweep over all 4096 rows of the glyph store
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned MaxPrinted    = 100;

  typedef struct packed {
    logic             kind;
    logic [CellW-1:0] column;
    logic [CellW-1:0] text_row;
    logic [LineW-1:0] pixel_line;
    logic [PixW-1:0]  pixels;
    logic             last;
  } cell_write_t;

  class glyph_scoreboard;
    logic [PixW-1:0] font [1 << AddrW];
    int unsigned     n_cols;
    int unsigned     n_rows;
    int unsigned     cur_col;
    int unsigned     cur_row;
    cell_write_t     due[$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     requests;
    int unsigned     loads;
    int unsigned     scrolls;
    int unsigned     wraps;

    function new(int unsigned cols, int unsigned rows);
      n_cols = cols;
      n_rows = rows;
      foreach (font[i]) font[i] = '0;
      cur_col  = 0;
      cur_row  = 0;
      errors   = 0;
      checked  = 0;
      requests = 0;
      loads    = 0;
      scrolls  = 0;
      wraps    = 0;
    endfunction

    function void push_write(logic kind, int unsigned col, int unsigned row,
                             int unsigned line, logic [PixW-1:0] bits);
      cell_write_t w;
      w.kind       = kind;
      w.column     = CellW'(col);
      w.text_row   = CellW'(row);
      w.pixel_line = LineW'(line);
      w.pixels     = bits;
      w.last       = 1'b0;
      due.push_back(w);
    endfunction

    function void scroll_if_past_end();
      if (cur_row >= n_rows) begin
        push_write(KIND_SCROLL, 0, 0, 0, '0);
        cur_row = n_rows - 1;
        scrolls++;
      end
    endfunction

    function void draw(logic [CodeW-1:0] code);
      for (int unsigned ly = 0; ly < GlyphLines; ly++)
        push_write(KIND_GLYPH, cur_col, cur_row, ly, font[{code, LineW'(ly)}]);
      cur_col++;
      if (cur_col >= n_cols) begin
        cur_col = 0;
        cur_row++;
        wraps++;
      end
      scroll_if_past_end();
    endfunction

    function void note_request(logic rtype, logic [CodeW-1:0] code,
                               logic [LineW-1:0] line, logic [PixW-1:0] bits);
      int unsigned before_cnt;
      cell_write_t tail;
      before_cnt = due.size();
      requests++;
      if (rtype == REQ_LOAD) begin
        font[{code, line}] = bits;
        loads++;
        return;
      end
      case (code)
        CHR_NL: begin
          cur_col = 0;
          cur_row++;
          scroll_if_past_end();
        end
        CHR_CR:  cur_col = 0;
        CHR_BS: begin
          if (cur_col > 0) cur_col--;
          draw(CHR_SPACE);
          if (cur_col > 0) cur_col--;
        end
        CHR_NUL: ;
        default: draw(code);
      endcase
      if (due.size() > before_cnt) begin
        tail      = due.pop_back();
        tail.last = 1'b1;
        due.push_back(tail);
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= MaxPrinted)
        $display("%0t MISMATCH %s: got 'h%0h, expected 'h%0h (after %0d writes)",
                 $realtime, what, got, want, checked);
    endtask

    task check_result(cell_write_t got);
      cell_write_t want;
      if (due.size() == 0) begin
        report("result with nothing due, kind", got.kind, 0);
        return;
      end
      want = due.pop_front();
      checked++;
      if (got.kind != want.kind) report("kind", got.kind, want.kind);
      if (got.column != want.column) report("column", got.column, want.column);
      if (got.text_row != want.text_row) report("text_row", got.text_row, want.text_row);
      if (got.pixel_line != want.pixel_line)
        report("pixel_line", got.pixel_line, want.pixel_line);
      if (got.pixels != want.pixels) report("pixels", got.pixels, want.pixels);
      if (got.last != want.last) report("last", got.last, want.last);
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             req_type;
  logic [CodeW-1:0] char_code;
  logic [LineW-1:0] glyph_line;
  logic [PixW-1:0]  row_bits;
  logic             result_valid;
  logic             kind;
  logic [CellW-1:0] column;
  logic [CellW-1:0] text_row;
  logic [LineW-1:0] pixel_line;
  logic [PixW-1:0]  pixels;
  logic             last;

  glyph_scoreboard  sb;
  int unsigned      n_sent;
  int unsigned      burst_left;
  int unsigned      stall_count;
  bit               progress;
  cell_write_t      seen;

  text_console_glyph_renderer #(
    .COLUMNS (Columns),
    .ROWS    (Rows)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type),
    .char_code_i    (char_code),
    .glyph_line_i   (glyph_line),
    .row_bits_i     (row_bits),
    .result_valid_o (result_valid),
    .kind_o         (kind),
    .column_o       (column),
    .text_row_o     (text_row),
    .pixel_line_o   (pixel_line),
    .pixels_o       (pixels),
    .last_o         (last)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // monitor: requests and results are sampled with their pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (start && !busy) begin
        sb.note_request(req_type, char_code, glyph_line, row_bits);
        progress = 1'b1;
      end
      if (result_valid) begin
        seen.kind       = kind;
        seen.column     = column;
        seen.text_row   = text_row;
        seen.pixel_line = pixel_line;
        seen.pixels     = pixels;
        seen.last       = last;
        sb.check_result(seen);
        progress = 1'b1;
      end
      if (progress) stall_count = 0;
      else stall_count++;
      if (stall_count >= WatchdogLimit) begin
        $display("watchdog: nothing accepted for %0d cycles", stall_count);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // after the initial setup, start is lowered only here, and time always advances before returning
  task automatic idle(int unsigned cycles);
    start      <= 1'b0;
    req_type   <= 1'($urandom_range(0, 1));
    char_code  <= CodeW'($urandom_range(0, 255));
    glyph_line <= LineW'($urandom_range(0, 15));
    row_bits   <= PixW'($urandom_range(0, 65535));
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send(logic rtype, logic [CodeW-1:0] code, logic [LineW-1:0] line,
                      logic [PixW-1:0] bits);
    start      <= 1'b1;
    req_type   <= rtype;
    char_code  <= code;
    glyph_line <= line;
    row_bits   <= bits;
    do @(posedge clk_i); while (busy);
    if (!(rtype == REQ_PRINT && code == CHR_NUL)) n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 24);
      idle($urandom_range(1, 20));
    end
  endtask

  task automatic print_char(logic [CodeW-1:0] code);
    send(REQ_PRINT, code, LineW'($urandom_range(0, 15)), PixW'($urandom_range(0, 65535)));
  endtask

  task automatic load_row(logic [CodeW-1:0] code, logic [LineW-1:0] line,
                          logic [PixW-1:0] bits);
    send(REQ_LOAD, code, line, bits);
  endtask

  task automatic wait_drained();
    idle(1);
    while (sb.due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned      len;
    logic [CodeW-1:0] code;
    sb          = new(Columns, Rows);
    n_sent      = 0;
    burst_left  = 8;
    stall_count = 0;
    start      <= 1'b0;
    req_type   <= REQ_PRINT;
    char_code  <= '0;
    glyph_line <= '0;
    row_bits   <= '0;
    while (!rst_ni) @(posedge clk_i);

    // directed: field extremes, every control byte, clamps
    load_row(8'h41, 4'h0, 16'hFFFF);
    load_row(8'h41, LINE_LAST, 16'h8001);
    load_row(8'hFF, 4'h7, 16'hAAAA);
    load_row(CHR_SPACE, 4'h3, 16'h5555);
    load_row(CHR_NUL, 4'h0, 16'h0001);
    load_row(CHR_BS, 4'h5, 16'h1234);
    print_char(CHR_BS);               // backspace at column 0 clamps
    print_char(8'h41);
    print_char(8'hFF);
    print_char(8'h01);
    print_char(CHR_NUL);
    print_char(CHR_CR);
    print_char(8'h41);
    print_char(8'h7F);
    print_char(CHR_BS);               // blank over the previous cell
    print_char(CHR_NL);
    print_char(8'h41);
    print_char(CHR_SPACE);
    load_row(8'h41, 4'h8, 16'h0000);
    print_char(8'h41);

    // hold off until the block has delivered everything
    wait_drained();

    while (n_sent < NumItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 80) : $urandom_range(1, 12);
          repeat (len) print_char(CodeW'($urandom_range(0, 255)));
        end
        3, 4: repeat ($urandom_range(1, 24)) print_char(CHR_NL);
        5, 6: begin
          code = ($urandom_range(0, 3) == 0) ? CHR_SPACE : CodeW'($urandom_range(0, 255));
          for (int unsigned ly = 0; ly < GlyphLines; ly++)
            load_row(code, LineW'(ly), PixW'($urandom_range(0, 65535)));
        end
        7: load_row(CodeW'($urandom_range(0, 255)), LineW'($urandom_range(0, 15)),
                    PixW'($urandom_range(0, 65535)));
        8: begin
          case ($urandom_range(0, 3))
            0: print_char(CHR_CR);
            1: print_char(CHR_BS);
            2: print_char(CHR_NUL);
            default: print_char(CHR_NL);
          endcase
        end
        default: send(1'($urandom_range(0, 1)), CodeW'($urandom_range(0, 255)),
                      LineW'($urandom_range(0, 15)), PixW'($urandom_range(0, 65535)));
      endcase
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.due.size() != 0) sb.report("results never delivered", 0, sb.due.size());

    $display("Covered %0d requests (%0d glyph row loads), %0d writes checked,",
             sb.requests, sb.loads, sb.checked);
    $display("including %0d scrolls and %0d line wraps", sb.scrolls, sb.wraps);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
